// ===== design/hole_fit_allocator_assert.svh =====
// Assertion macros used by the allocator RTL.
`ifndef HOLE_FIT_ALLOCATOR_ASSERT_SVH
`define HOLE_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HFA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hfa_pkg;

  // Input word
  typedef struct packed {
    logic        action;
    logic [6:0]  hole_index;
    logic [15:0] hole_size;
    logic [15:0] request_size;
  } hfa_in_t;

  // Result word
  typedef struct packed {
    logic        found;
    logic [6:0]  chosen_index;
    logic [15:0] leftover_size;
  } hfa_out_t;

  // Action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Register indexes
  localparam logic REG_STRATEGY   = 1'b0;
  localparam logic REG_HOLE_COUNT = 1'b1;

  localparam logic [7:0] HOLE_COUNT_RESET = 8'd100;

  // Reach of the 7-bit hole index
  localparam int INDEX_REACH = 128;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_NEXT  = 2'd1,
    STRAT_BEST  = 2'd2,
    STRAT_WORST = 2'd3
  } strat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/hole_fit_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Load: written straight into the table, no result; busy stays low.
// Allocate: n = min(hole_count, table depth); the scan reads one hole per cycle
// through the table's single read port, so done pulses once the last hole read
// has been judged; the next word is taken once the block is idle again.
// Synchronous reset: strategy first fit, hole_count 100, all holes zero,
// next-fit pointer zero; the result strobe has no stall.
`include "hole_fit_allocator_assert.svh"

module hole_fit_allocator import hfa_pkg::*; #(
  parameter int MAX_HOLES = 128,
  parameter int SIZE_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire hfa_in_t  cmd,
  output logic          done,
  output hfa_out_t      result,
  input  wire logic     cfg_we,
  input  wire logic     cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int DEPTH = (MAX_HOLES < INDEX_REACH) ? MAX_HOLES : INDEX_REACH;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (SIZE_BITS > 16) ? SIZE_BITS : 16;

  state_t               state, state_next;
  strat_t               strategy;
  logic [7:0]           hole_count;
  logic [IDX_W-1:0]     nfs, nfs_next;
  logic [CNT_W-1:0]     n_cnt, n_next;
  logic [CNT_W-1:0]     k, k_next;
  logic [IDX_W-1:0]     addr, addr_next;
  logic                 pending, pending_next;
  logic [IDX_W-1:0]     cmp_idx, cmp_idx_next;
  logic [15:0]          req, req_next;
  logic                 found, found_next;
  logic [IDX_W-1:0]     hit_idx, hit_next;
  logic [SIZE_BITS-1:0] best_left, best_next;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [SIZE_BITS-1:0] rd_entry;

  logic [CNT_W-1:0]     n_clamp;
  logic [CNT_W-1:0]     addr_inc;
  logic [CW-1:0]        entry_ext, req_ext, left_full, size_ext, left_out;
  logic [SIZE_BITS-1:0] left;
  logic                 fits, better;

  hfa_hole_table #(
    .DEPTH     (DEPTH),
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (addr),
    .rd_entry (rd_entry)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy   <= STRAT_FIRST;
      hole_count <= HOLE_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRATEGY:   strategy   <= strat_t'(cfg_data[1:0]);
        REG_HOLE_COUNT: hole_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared compare and subtract unit
  always_comb begin
    entry_ext = CW'(rd_entry);
    req_ext   = CW'(req);
    fits      = (entry_ext >= req_ext);
    left_full = entry_ext - req_ext;
    left      = left_full[SIZE_BITS-1:0];
    case (strategy)
      STRAT_BEST:  better = !found || (left < best_left);
      STRAT_WORST: better = !found || (left > best_left);
      default:     better = !found;
    endcase
  end

  assign n_clamp  = (32'(hole_count) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(hole_count);
  assign addr_inc = CNT_W'(addr) + CNT_W'(1);
  assign size_ext = CW'(cmd.hole_size);

  // Sequencer: next state, table writes
  always_comb begin
    state_next   = state;
    nfs_next     = nfs;
    n_next       = n_cnt;
    k_next       = k;
    addr_next    = addr;
    pending_next = 1'b0;
    cmp_idx_next = addr;
    req_next     = req;
    found_next   = found;
    hit_next     = hit_idx;
    best_next    = best_left;
    wr_en        = 1'b0;
    wr_addr      = hit_idx;
    wr_data      = best_left;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd.action == ACT_ALLOC) begin
            state_next = ST_SCAN;
            n_next     = n_clamp;
            k_next     = '0;
            addr_next  = (strategy == STRAT_NEXT && CNT_W'(nfs) < n_clamp) ? nfs : '0;
            req_next   = cmd.request_size;
            found_next = 1'b0;
            hit_next   = '0;
            best_next  = '0;
          end else if (32'(cmd.hole_index) < DEPTH) begin
            wr_en   = 1'b1;
            wr_addr = cmd.hole_index[IDX_W-1:0];
            wr_data = size_ext[SIZE_BITS-1:0];
          end
        end
      end
      ST_SCAN: begin
        // Issue the next read, wrapping at the searched count
        if (k < n_cnt) begin
          k_next       = k + CNT_W'(1);
          addr_next    = (addr_inc == n_cnt) ? '0 : addr_inc[IDX_W-1:0];
          pending_next = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
        // Judge the entry read last cycle
        if (pending && fits && better) begin
          found_next = 1'b1;
          hit_next   = cmp_idx;
          best_next  = left;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
        if (found) begin
          wr_en = 1'b1;
          if (strategy == STRAT_NEXT) begin
            nfs_next = hit_idx;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      nfs     <= '0;
      pending <= 1'b0;
      found   <= 1'b0;
      hit_idx <= '0;
      k       <= '0;
      n_cnt   <= '0;
      addr    <= '0;
    end else begin
      state   <= state_next;
      nfs     <= nfs_next;
      pending <= pending_next;
      found   <= found_next;
      hit_idx <= hit_next;
      k       <= k_next;
      n_cnt   <= n_next;
      addr    <= addr_next;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx   <= cmp_idx_next;
    req       <= req_next;
    best_left <= best_next;
  end

  // Drive the result word during the done cycle
  assign left_out             = CW'(best_left);
  assign busy                 = (state != ST_IDLE);
  assign done                 = (state == ST_DONE);
  assign result.found         = found;
  assign result.chosen_index  = 7'(hit_idx);
  assign result.leftover_size = left_out[15:0];

  `HFA_ASSERT_SAME(a_scan_bound, clk, rst, state == ST_SCAN, k <= n_cnt,
                   "scan counter passed the searched count")
  `HFA_ASSERT_SAME(a_miss_zero, clk, rst, done && !result.found,
                   result.chosen_index == 7'd0 && result.leftover_size == 16'd0,
                   "miss reported with nonzero fields")
  `HFA_ASSERT_NEXT(a_alloc_busy, clk, rst, start && !busy && cmd.action == ACT_ALLOC,
                   state == ST_SCAN, "allocate did not start a scan")
  `HFA_ASSERT_NEXT(a_done_once, clk, rst, done, !done && !busy,
                   "result strobe held past one cycle")
  `HFA_ASSERT_SAME(a_hit_range, clk, rst, done && result.found,
                   CNT_W'(hit_idx) < n_cnt, "hit index outside searched holes")

endmodule

`default_nettype wire

// ===== design/hfa_hole_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hfa_hole_table import hfa_pkg::*; #(
  parameter int DEPTH     = 128,
  parameter int IDX_W     = 7,
  parameter int SIZE_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [IDX_W-1:0]     wr_addr,
  input  wire logic [SIZE_BITS-1:0] wr_data,
  input  wire logic [IDX_W-1:0]     rd_addr,
  output logic      [SIZE_BITS-1:0] rd_entry
);

  logic [SIZE_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_valid;

  // Write the entry and its valid bit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read; an entry never written reads as zero
  always_ff @(posedge clk) begin
    rd_data  <= mem[rd_addr];
    rd_valid <= valid[rd_addr];
  end

  assign rd_entry = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire
